// File: sv/gdad_pkg.sv
package gdad_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int OFF_W   = 16;
  localparam int DN_W    = 22;
  localparam int YDAY_W  = 9;

  localparam logic [YEAR_W-1:0]  MAX_YEAR = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTHS   = 4'd12;

  localparam logic [8:0]  DAYS_1Y   = 9'd365;
  localparam logic [10:0] DAYS_4Y   = 11'd1461;
  localparam logic [15:0] DAYS_100Y = 16'd36524;
  localparam logic [17:0] DAYS_400Y = 18'd146097;

  // reciprocals for exact floor division by constants
  localparam int R100_K = 21;
  localparam longint unsigned R100_ML = ((64'd1 << R100_K) + 64'd99) / 64'd100;
  localparam logic [14:0] R100_M = 15'(R100_ML);

  localparam int R400_K = 40;
  localparam longint unsigned R400_ML = ((64'd1 << R400_K) + 64'd146096) / 64'd146097;
  localparam logic [22:0] R400_M = 23'(R400_ML);

  localparam int R4_K = 27;
  localparam longint unsigned R4_ML = ((64'd1 << R4_K) + 64'd1460) / 64'd1461;
  localparam logic [16:0] R4_M = 17'(R4_ML);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_DATE = 2'd1,
    ST_RANGE    = 2'd2
  } status_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  in_year;
    logic [MONTH_W-1:0] in_month;
    logic [DAY_W-1:0]   in_day;
    logic [OFF_W-1:0]   offset_days;
  } in_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  out_year;
    logic [MONTH_W-1:0] out_month;
    logic [DAY_W-1:0]   out_day;
    logic [DN_W-1:0]    day_number;
    status_t            status;
  } out_t;

  typedef struct packed {
    logic bad;
    logic over;
  } flags_t;

  typedef struct packed {
    logic [DN_W-1:0] n;
    flags_t          flags;
  } fwd_t;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [YDAY_W-1:0] yday;
    logic              leap;
    logic [DN_W-1:0]   n;
    flags_t            flags;
  } cyc_t;

  // days before a month, month index from 0
  function automatic logic [YDAY_W-1:0] cum_days(input logic [MONTH_W-1:0] idx);
    logic [YDAY_W-1:0] d;
    case (idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// File: sv/gdad_fwd.sv
module gdad_fwd (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_vld,
  input  gdad_pkg::in_t   cmd,
  output logic            fwd_vld,
  output gdad_pkg::fwd_t  fwd
);
  import gdad_pkg::*;

  logic [YEAR_W-1:0] y;
  logic [YEAR_W-1:0] p;
  logic [28:0]       qp_prod;
  logic [28:0]       qy_prod;
  flags_t            flags_in;

  // stage a: products
  logic              a_vld;
  logic [YEAR_W-1:0] a_y;
  logic [YEAR_W-1:0] a_p;
  logic [22:0]       a_m365;
  logic [7:0]        a_qp100;
  logic [7:0]        a_qy100;
  logic [MONTH_W-1:0] a_month;
  logic [DAY_W-1:0]  a_day;
  logic [OFF_W-1:0]  a_off;
  flags_t            a_flags;

  // stage b: year base and day of year
  logic              b_vld;
  logic [22:0]       b_base;
  logic [YDAY_W-1:0] b_extra;
  logic [OFF_W-1:0]  b_off;
  flags_t            b_flags;

  logic [YEAR_W-1:0] y100;
  logic              leap;
  logic [22:0]       base_next;
  logic [YDAY_W-1:0] extra_next;

  always_comb begin
    y        = cmd.in_year;
    p        = y - 14'd1;
    qp_prod  = 29'(p) * 29'(R100_M);
    qy_prod  = 29'(y) * 29'(R100_M);
    flags_in.bad  = (y == '0) || (cmd.in_month == '0) || (cmd.in_month > MONTHS)
                    || (cmd.in_day == '0);
    flags_in.over = (y > MAX_YEAR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= cmd_vld;
    end
    a_y     <= y;
    a_p     <= p;
    a_m365  <= 23'(p) * 23'(DAYS_1Y);
    a_qp100 <= qp_prod[28:R100_K];
    a_qy100 <= qy_prod[28:R100_K];
    a_month <= cmd.in_month;
    a_day   <= cmd.in_day;
    a_off   <= cmd.offset_days;
    a_flags <= flags_in;
  end

  always_comb begin
    y100 = 14'(a_qy100) * 14'd100;
    // divisible by 4, and not a century unless divisible by 400
    leap = (a_y[1:0] == 2'b00) && ((a_y != y100) || (a_qy100[1:0] == 2'b00));
    base_next = a_m365 + 23'(a_p[YEAR_W-1:2]) - 23'(a_qp100) + 23'(a_qp100[7:2]);
    extra_next = cum_days(a_month - 4'd1) + {8'b0, (leap && (a_month > 4'd2))}
                 + 9'(a_day);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= a_vld;
    end
    b_base  <= base_next;
    b_extra <= extra_next;
    b_off   <= a_off;
    b_flags <= a_flags;
  end

  // stage c: zero-based serial of the result
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_vld <= 1'b0;
    end else begin
      fwd_vld <= b_vld;
    end
    fwd.n     <= 22'(b_base + 23'(b_extra) + 23'(b_off) - 23'd1);
    fwd.flags <= b_flags;
  end

endmodule

// File: sv/gdad_cyc.sv
module gdad_cyc (
  input  logic            clk,
  input  logic            rst,
  input  logic            fwd_vld,
  input  gdad_pkg::fwd_t  fwd,
  output logic            cyc_vld,
  output gdad_pkg::cyc_t  cyc
);
  import gdad_pkg::*;

  logic [44:0] q400_prod;

  // stage d: 400-year cycles
  logic            d_vld;
  logic [4:0]      d_q400;
  logic [DN_W-1:0] d_n;
  flags_t          d_flags;

  // stage e: day within 400-year cycle
  logic            e_vld;
  logic [17:0]     e_r;
  logic [4:0]      e_q400;
  logic [DN_W-1:0] e_n;
  flags_t          e_flags;

  // stage f: centuries
  logic            f_vld;
  logic [1:0]      f_c;
  logic [15:0]     f_r1;
  logic [4:0]      f_q400;
  logic [DN_W-1:0] f_n;
  flags_t          f_flags;
  logic [1:0]      c_next;

  // stage g: 4-year blocks
  logic            g_vld;
  logic [4:0]      g_q4;
  logic [15:0]     g_r1;
  logic [1:0]      g_c;
  logic [4:0]      g_q400;
  logic [DN_W-1:0] g_n;
  flags_t          g_flags;
  logic [31:0]     q4_prod;

  // stage h: day within block, year base
  logic              h_vld;
  logic [10:0]       h_r2;
  logic [YEAR_W-1:0] h_yb;
  logic              h_cent;
  logic [DN_W-1:0]   h_n;
  flags_t            h_flags;

  logic [1:0] y1;

  always_comb begin
    q400_prod = 45'(fwd.n) * 45'(R400_M);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else begin
      d_vld <= fwd_vld;
    end
    d_q400  <= q400_prod[44:R400_K];
    d_n     <= fwd.n;
    d_flags <= fwd.flags;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else begin
      e_vld <= d_vld;
    end
    e_r     <= 18'(d_n - 22'(d_q400) * 22'(DAYS_400Y));
    e_q400  <= d_q400;
    e_n     <= d_n;
    e_flags <= d_flags;
  end

  // the last day of a 400-year cycle stays in the fourth century
  always_comb begin
    c_next = 2'(e_r >= 18'(DAYS_100Y)) + 2'(e_r >= 18'(2 * DAYS_100Y))
             + 2'(e_r >= 18'(3 * DAYS_100Y));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else begin
      f_vld <= e_vld;
    end
    f_c     <= c_next;
    f_r1    <= 16'(e_r - 18'(c_next) * 18'(DAYS_100Y));
    f_q400  <= e_q400;
    f_n     <= e_n;
    f_flags <= e_flags;
  end

  always_comb begin
    q4_prod = 32'(f_r1) * 32'(R4_M);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_vld <= 1'b0;
    end else begin
      g_vld <= f_vld;
    end
    g_q4    <= q4_prod[31:R4_K];
    g_r1    <= f_r1;
    g_c     <= f_c;
    g_q400  <= f_q400;
    g_n     <= f_n;
    g_flags <= f_flags;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_vld <= 1'b0;
    end else begin
      h_vld <= g_vld;
    end
    h_r2    <= 11'(g_r1 - 16'(g_q4) * 16'(DAYS_4Y));
    h_yb    <= 14'(g_q400) * 14'd400 + 14'(g_c) * 14'd100 + 14'(g_q4) * 14'd4;
    // century year that is not a multiple of 400
    h_cent  <= (g_q4 == 5'd24) && (g_c != 2'd3);
    h_n     <= g_n;
    h_flags <= g_flags;
  end

  // stage i: year within block, day of year
  always_comb begin
    y1 = 2'(h_r2 >= 11'(DAYS_1Y)) + 2'(h_r2 >= 11'(2 * DAYS_1Y))
         + 2'(h_r2 >= 11'(3 * DAYS_1Y));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cyc_vld <= 1'b0;
    end else begin
      cyc_vld <= h_vld;
    end
    cyc.year  <= h_yb + 14'(y1) + 14'd1;
    cyc.yday  <= 9'(h_r2 - 11'(y1) * 11'(DAYS_1Y));
    cyc.leap  <= (y1 == 2'd3) && !h_cent;
    cyc.n     <= h_n;
    cyc.flags <= h_flags;
  end

endmodule

// File: sv/gdad_cal.sv
module gdad_cal (
  input  logic            clk,
  input  logic            rst,
  input  logic            cyc_vld,
  input  gdad_pkg::cyc_t  cyc,
  output logic            done,
  output gdad_pkg::out_t  res
);
  import gdad_pkg::*;

  logic [MONTH_W-1:0] mo_next;
  logic [YDAY_W-1:0]  thr;

  // stage j: month index
  logic               j_vld;
  logic [MONTH_W-1:0] j_mo;
  logic [YDAY_W-1:0]  j_yday;
  logic               j_leap;
  logic [YEAR_W-1:0]  j_year;
  logic [DN_W-1:0]    j_n;
  logic               j_bad;
  logic               j_over;

  // stage k: day of month and result
  logic [YDAY_W-1:0]  start_day;
  out_t               res_next;

  always_comb begin
    mo_next = '0;
    thr     = '0;
    for (int i = 1; i < 12; i++) begin
      thr = cum_days(4'(i)) + {8'b0, (cyc.leap && (i >= 2))};
      if (cyc.yday >= thr) begin
        mo_next = mo_next + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      j_vld <= 1'b0;
    end else begin
      j_vld <= cyc_vld;
    end
    j_mo   <= mo_next;
    j_yday <= cyc.yday;
    j_leap <= cyc.leap;
    j_year <= cyc.year;
    j_n    <= cyc.n;
    j_bad  <= cyc.flags.bad;
    j_over <= cyc.flags.over || (cyc.year > MAX_YEAR);
  end

  always_comb begin
    start_day = cum_days(j_mo) + {8'b0, (j_leap && (j_mo >= 4'd2))};
    res_next  = '0;
    if (j_bad) begin
      res_next.status = ST_BAD_DATE;
    end else if (j_over) begin
      res_next.status = ST_RANGE;
    end else begin
      res_next.out_year   = j_year;
      res_next.out_month  = j_mo + 4'd1;
      res_next.out_day    = 5'(j_yday - start_day + 9'd1);
      res_next.day_number = j_n + 22'd1;
      res_next.status     = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= j_vld;
    end
    res <= res_next;
  end

endmodule

// File: sv/gregorian_date_add_days_unit.sv
// Gregorian date plus day offset.
// A transaction is taken at a rising edge with start high and busy low; cmd
// carries the start date (year, month, day) and the days to add. busy is high
// only while rst is asserted, so a new transaction can be issued every cycle.
// The result appears on res for exactly one cycle, marked by done, once the
// transaction has passed all pipeline stages; results leave in issue order.
// res holds the new date, its serial day number (day 1 is 0001-01-01) and a
// status: ok, invalid start date (month not 1..12, day 0 or year 0), or a
// start or result year beyond 9999; all other fields are zero when status is not ok.
// A day past the month end rolls forward into the next month.
// Throughput is one transaction per cycle outside reset; the pipeline has
// eleven stages: three stages of reciprocal multiplies and adds to
// form the serial number, six stages that split it into 400-, 100-, 4- and
// 1-year cycles, and two for the month lookup and the output register.
// The receiver cannot stall; done and res are never held.
// Synchronous reset empties the pipeline: no done follows for transactions
// taken before reset.
module gregorian_date_add_days_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  gdad_pkg::in_t  cmd,
  output logic           done,
  output gdad_pkg::out_t res
);
  import gdad_pkg::*;

  logic cmd_vld;
  logic fwd_vld;
  fwd_t fwd;
  logic cyc_vld;
  cyc_t cyc;

  assign busy    = rst;
  assign cmd_vld = start && !busy;

  gdad_fwd u_fwd (
    .clk     (clk),
    .rst     (rst),
    .cmd_vld (cmd_vld),
    .cmd     (cmd),
    .fwd_vld (fwd_vld),
    .fwd     (fwd)
  );

  gdad_cyc u_cyc (
    .clk     (clk),
    .rst     (rst),
    .fwd_vld (fwd_vld),
    .fwd     (fwd),
    .cyc_vld (cyc_vld),
    .cyc     (cyc)
  );

  gdad_cal u_cal (
    .clk     (clk),
    .rst     (rst),
    .cyc_vld (cyc_vld),
    .cyc     (cyc),
    .done    (done),
    .res     (res)
  );

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (res.status != ST_OK)) |->
      (res.out_year == '0) && (res.out_month == '0) && (res.out_day == '0)
      && (res.day_number == '0))
    else $error("failed transaction carries a nonzero date");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    (done && (res.status == ST_OK)) |->
      (res.out_month >= 4'd1) && (res.out_month <= MONTHS))
    else $error("month out of range on ok result");

  a_day_range: assert property (@(posedge clk) disable iff (rst)
    (done && (res.status == ST_OK)) |-> (res.out_day != '0))
    else $error("day zero on ok result");

  a_year_range: assert property (@(posedge clk) disable iff (rst)
    (done && (res.status == ST_OK)) |->
      (res.out_year != '0) && (res.out_year <= MAX_YEAR) && (res.day_number != '0))
    else $error("year or day number out of range on ok result");

endmodule
